// ===== rtl/multi_axis_step_dir_generator_defines.svh =====
// ----------------------------------------------------------------------------
// multi_axis_step_dir_generator_defines.svh
// Assertion macros for the step/direction generator.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_STEP_DIR_GENERATOR_DEFINES_SVH
`define MULTI_AXIS_STEP_DIR_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, quiet while reset is asserted
`define SDG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, active through reset as well
`define SDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDG_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sdg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types and constants of the step/direction generator.
// ----------------------------------------------------------------------------
package sdg_pkg;

    localparam int NUM_MOTORS_DEF = 4;
    localparam int NUM_REGS       = 4;
    localparam int OUT_BITS       = 4;
    localparam int POS_W          = 32;
    localparam int BACKOFF_W      = 21;
    localparam int REG_IDX_W      = 2;
    localparam int CH_W           = 2;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_SET  = 2'd1,
        MODE_HOME = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    // per-lane command, one-hot or all zero
    typedef struct packed {
        logic tick;
        logic set_tgt;
        logic home;
    } t_lane_cmd;

    localparam logic [BACKOFF_W-1:0] BACKOFF_RST [NUM_REGS] = '{
        BACKOFF_W'(-600), BACKOFF_W'(650), BACKOFF_W'(-2000), BACKOFF_W'(3500)
    };

    localparam logic [POS_W-1:0] HOME_TGT_POS = POS_W'(5);
    localparam logic [POS_W-1:0] HOME_TGT_NEG = POS_W'(-5);

endpackage

// ===== rtl/multi_axis_step_dir_generator.sv =====
// ----------------------------------------------------------------------------
// multi_axis_step_dir_generator
// Step/direction generator for NUM_MOTORS stepper motors (four by default).
// ----------------------------------------------------------------------------
// One result word per input word. Each input word is registered, then
// processed combinationally by the per-motor lanes and captured in the
// output register. The result word passes the input register, then the
// output register, where it waits while the receiver stalls. With
// the output taken every cycle, one word is accepted every cycle.
// Throughput is set by the lane update (compare, +/-1, compare) which fits
// between the input and output registers. The input stage keeps accepting
// while a finished result waits, as long as that stage has room.
// Input tuser carries the command: mode 0 tick, 1 set target, 2 home; a
// command to a motor number at or above NUM_MOTORS is ignored. Homing moves
// a motor to position minus its backoff, then zeroes the position and sets
// the target to -5 (positive backoff) or +5 (otherwise). Backoff registers
// are written through the cfg port; the user must write them only while
// the block is idle (the block does not enforce it). Only motors 0..3 are output.
// ----------------------------------------------------------------------------
`include "multi_axis_step_dir_generator_defines.svh"

module multi_axis_step_dir_generator
    import sdg_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [31:0] target_value
    input  logic [3:0]           s_axis_tuser,  // [1:0] mode, [3:2] channel
    // result words
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // [3:0] step_toggle, [7:4] direction,
                                                // [8] busy_res, [15:9] zero
    // backoff registers
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_addr,
    input  logic [BACKOFF_W-1:0] i_cfg_data
);

    // input stage
    logic             r_in_valid;
    t_mode            r_mode;
    logic [CH_W-1:0]  r_ch;
    logic [POS_W-1:0] r_tv;
    logic             w_accept;
    logic             w_advance;

    // backoff registers
    logic [BACKOFF_W-1:0] r_backoff [NUM_REGS];

    // lanes
    logic [NUM_MOTORS-1:0] w_sel;
    logic [NUM_MOTORS-1:0] w_step_vec;
    logic [NUM_MOTORS-1:0] w_dir_vec;
    logic [OUT_BITS-1:0]   w_step4;
    logic [OUT_BITS-1:0]   w_dir4;
    logic                  w_hit;

    // busy and output stage
    logic                r_busy, n_busy;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_step;
    logic [OUT_BITS-1:0] r_out_dir;
    logic                r_out_busy;

    // handshake: the work stage fires when its result slot is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(s_axis_tuser[1:0]);
            r_ch   <= s_axis_tuser[3:2];
            r_tv   <= s_axis_tdata;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_backoff[i] <= BACKOFF_RST[i];
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i_cfg_addr == REG_IDX_W'(i)) begin
                    r_backoff[i] <= i_cfg_data;
                end
            end
        end
    end

    // motor lanes
    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
        t_lane_cmd            w_cmd;
        logic [BACKOFF_W-1:0] w_back;

        assign w_sel[m]      = ({1'b0, r_ch} == 3'(m));
        assign w_cmd.tick    = w_advance && (r_mode == MODE_TICK);
        assign w_cmd.set_tgt = w_advance && (r_mode == MODE_SET) && w_sel[m];
        assign w_cmd.home    = w_advance && (r_mode == MODE_HOME) && w_sel[m];

        // motors past the register file home with zero backoff
        if (m < NUM_REGS) begin : g_reg
            assign w_back = r_backoff[m];
        end else begin : g_zero
            assign w_back = '0;
        end

        sdg_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_backoff  (w_back),
            .i_target   (r_tv),
            .o_step     (w_step_vec[m]),
            .o_dir_next (w_dir_vec[m])
        );
    end

    assign w_hit = |w_sel;

    // only motors 0..3 are reported
    for (genvar b = 0; b < OUT_BITS; b++) begin : g_out
        if (b < NUM_MOTORS) begin : g_on
            assign w_step4[b] = w_step_vec[b];
            assign w_dir4[b]  = w_dir_vec[b];
        end else begin : g_off
            assign w_step4[b] = 1'b0;
            assign w_dir4[b]  = 1'b0;
        end
    end

    always_comb begin
        unique case (r_mode) inside
            MODE_TICK:            n_busy = |w_step_vec;
            MODE_SET, MODE_HOME:  n_busy = w_hit ? 1'b1 : r_busy;
            default:              n_busy = r_busy;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_busy <= n_busy;
            end
            r_out_valid <= w_advance || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_step <= w_step4;
            r_out_dir  <= w_dir4;
            r_out_busy <= n_busy;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_busy, r_out_dir, r_out_step};

    // checks
    `SDG_ASSERT(a_step_means_busy, i_clk, i_rst_n, (r_out_valid && (|r_out_step)) |-> r_out_busy, "stepping result without busy")
    `SDG_ASSERT(a_step_only_on_tick, i_clk, i_rst_n, (r_mode != MODE_TICK) |-> (w_step_vec == '0), "step outside a tick")
    `SDG_ASSERT(a_in_stage_full, i_clk, i_rst_n, (r_in_valid && !w_advance) |-> !s_axis_tready, "input taken while stage full")
    `SDG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "stages not empty after reset")

endmodule

// ===== rtl/sdg_lane.sv =====
// ----------------------------------------------------------------------------
// sdg_lane
// One motor: position, target, homing flag and direction level.
// ----------------------------------------------------------------------------
module sdg_lane
    import sdg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane_cmd            i_cmd,
    input  logic [BACKOFF_W-1:0] i_backoff,
    input  logic [POS_W-1:0]     i_target,
    output logic                 o_step,
    output logic                 o_dir_next
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tgt, n_tgt;
    logic             r_hom, n_hom;
    logic             r_dir, n_dir;
    logic [POS_W-1:0] w_backoff;
    logic             w_back_pos;

    assign w_backoff  = {{(POS_W-BACKOFF_W){i_backoff[BACKOFF_W-1]}}, i_backoff};
    assign w_back_pos = !i_backoff[BACKOFF_W-1] && (|i_backoff);

    always_comb begin
        n_pos  = r_pos;
        n_tgt  = r_tgt;
        n_hom  = r_hom;
        n_dir  = r_dir;
        o_step = 1'b0;
        if (i_cmd.tick) begin
            if (r_pos != r_tgt) begin
                o_step = 1'b1;
                if ($signed(r_tgt) > $signed(r_pos)) begin
                    n_dir = 1'b1;
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_dir = 1'b0;
                    n_pos = r_pos - POS_W'(1);
                end
            end
            // homing done: zero the position, target -5 after a positive backoff, else +5
            if (r_hom && (n_pos == r_tgt)) begin
                n_hom = 1'b0;
                n_pos = '0;
                n_tgt = w_back_pos ? HOME_TGT_NEG : HOME_TGT_POS;
            end
        end else if (i_cmd.set_tgt) begin
            n_tgt = i_target;
        end else if (i_cmd.home) begin
            n_hom = 1'b1;
            n_tgt = r_pos - w_backoff;
        end
    end

    assign o_dir_next = n_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_tgt <= '0;
            r_hom <= 1'b0;
            r_dir <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_tgt <= n_tgt;
            r_hom <= n_hom;
            r_dir <= n_dir;
        end
    end

endmodule

// ===== bench/tb_multi_axis_step_dir_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_axis_step_dir_generator
// Self-checking bench for the four-axis step/direction generator.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of motor positions, goals, homing
// flags, direction levels, busy and backoffs. Every word accepted on the
// input stream is run through it, and the predicted result word is queued.
// Words on the output stream are checked field by field in order. The run
// covers a directed opening, then three random phases with different
// backoff settings (small, extreme, random small). Sender bursts and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_multi_axis_step_dir_generator;
    import sdg_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int MAX_REPORTS = 10;

    // expected result word, fields as on m_axis_tdata
    typedef struct packed {
        logic [OUT_BITS-1:0] toggle;
        logic [OUT_BITS-1:0] dir;
        logic                busy;
    } t_step_word;

    // receiver stall behavior
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC
    } t_ready_style;

    // ------------------------------------------------------------------------
    // Scoreboard: motor state copy plus queue of predicted result words
    // ------------------------------------------------------------------------
    class step_dir_scoreboard;
        logic [POS_W-1:0]            axis_pos  [NUM_MOTORS_DEF];
        logic [POS_W-1:0]            axis_goal [NUM_MOTORS_DEF];
        logic                        axis_homing [NUM_MOTORS_DEF];
        logic                        axis_dir  [NUM_MOTORS_DEF];
        logic                        busy_now;
        logic signed [BACKOFF_W-1:0] backoff [NUM_REGS];
        t_step_word                  expected_words [$];
        int                          failures;

        function new();
            for (int m = 0; m < NUM_MOTORS_DEF; m++) begin
                axis_pos[m]    = '0;
                axis_goal[m]   = '0;
                axis_homing[m] = 1'b0;
                axis_dir[m]    = 1'b0;
            end
            for (int r = 0; r < NUM_REGS; r++) begin
                backoff[r] = BACKOFF_RST[r];
            end
            busy_now = 1'b0;
            failures = 0;
        endfunction

        function void set_backoff(int idx, logic [BACKOFF_W-1:0] val);
            backoff[idx] = val;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // advance the motor state by one accepted input word
        function void note_command(t_mode mode, logic [1:0] ch, logic [POS_W-1:0] tv);
            t_step_word          res;
            logic [OUT_BITS-1:0] toggle;
            logic [POS_W-1:0]    travel;
            toggle = '0;
            if (mode == MODE_TICK) begin
                for (int m = 0; m < NUM_MOTORS_DEF; m++) begin
                    if (axis_pos[m] != axis_goal[m]) begin
                        toggle[m] = 1'b1;
                        // signed compare decides the direction
                        if ($signed(axis_goal[m]) > $signed(axis_pos[m])) begin
                            axis_dir[m] = 1'b1;
                            axis_pos[m] = axis_pos[m] + POS_W'(1);
                        end else begin
                            axis_dir[m] = 1'b0;
                            axis_pos[m] = axis_pos[m] - POS_W'(1);
                        end
                    end
                end
                busy_now = |toggle;
                // homing finishes after the step: zero position, park at -/+5
                for (int m = 0; m < NUM_MOTORS_DEF; m++) begin
                    if (axis_homing[m] && axis_pos[m] == axis_goal[m]) begin
                        axis_homing[m] = 1'b0;
                        axis_pos[m]    = '0;
                        axis_goal[m]   = (backoff[m] > 0) ? HOME_TGT_NEG : HOME_TGT_POS;
                    end
                end
            end else if (mode == MODE_SET) begin
                busy_now      = 1'b1;
                axis_goal[ch] = tv;
            end else if (mode == MODE_HOME) begin
                busy_now        = 1'b1;
                axis_homing[ch] = 1'b1;
                travel          = {{(POS_W-BACKOFF_W){backoff[ch][BACKOFF_W-1]}}, backoff[ch]};
                axis_goal[ch]   = axis_pos[ch] - travel;
            end
            res.toggle = toggle;
            for (int m = 0; m < OUT_BITS; m++) begin
                res.dir[m] = axis_dir[m];
            end
            res.busy = busy_now;
            expected_words.push_back(res);
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("[%0t] %s: expected %0h, got %0h", $realtime, what, exp_val,
                         act_val);
            end
        endfunction

        // compare one output word against the oldest prediction
        function void check_word(logic [15:0] w);
            t_step_word exp_w;
            if (expected_words.size() == 0) begin
                flag("result word with nothing pending", 32'd0, {16'd0, w});
                return;
            end
            exp_w = expected_words.pop_front();
            if (w[3:0] != exp_w.toggle) begin
                flag("step_toggle", 32'(exp_w.toggle), 32'(w[3:0]));
            end
            if (w[7:4] != exp_w.dir) begin
                flag("direction", 32'(exp_w.dir), 32'(w[7:4]));
            end
            if (w[8] != exp_w.busy) begin
                flag("busy_res", 32'(exp_w.busy), 32'(w[8]));
            end
            if (w[15:9] != 7'd0) begin
                flag("tdata padding", 32'd0, 32'(w[15:9]));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata   = '0;   // [31:0] target_value
    logic [3:0]           s_axis_tuser   = '0;   // [1:0] mode, [3:2] channel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [15:0]          m_axis_tdata;          // [3:0] step_toggle, [7:4] direction,
                                                 // [8] busy_res, [15:9] zero
    logic                 i_cfg_we       = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_addr     = '0;
    logic [BACKOFF_W-1:0] i_cfg_data     = '0;

    multi_axis_step_dir_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    step_dir_scoreboard sb = new();

    t_ready_style ready_style = READY_ALWAYS;
    bit           gaps_on     = 1'b0;
    int           burst_left  = 0;
    int           cycle_count = 0;
    int           ready_phase = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: stall behavior set per phase
    always @(posedge i_clk) begin
        ready_phase++;
        case (ready_style)
            READY_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            READY_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                // periodic stall pattern derived from ready_phase
                m_axis_tready <= ((ready_phase % 11) < 7);
            end
        endcase
    end

    // result word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // present one word, hold until accepted, then update the prediction
    task automatic send_word(t_mode mode, logic [1:0] ch, logic [31:0] tv);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {ch, mode};
        s_axis_tdata  <= tv;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(mode, ch, tv);
    endtask

    // stop sending until every predicted word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write all four backoffs, block must be idle
    task automatic load_backoffs(input int vals [NUM_REGS]);
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= REG_IDX_W'(r);
            i_cfg_data <= BACKOFF_W'(vals[r]);
            @(posedge i_clk);
            sb.set_backoff(r, BACKOFF_W'(vals[r]));
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly ticks; set targets land near the motor so moves finish
    task automatic random_word();
        int          pick;
        logic [1:0]  ch;
        logic [31:0] tv;
        pick = $urandom_range(0, 99);
        ch   = 2'($urandom_range(0, 3));
        tv   = $urandom;
        if (pick < 55) begin
            send_word(MODE_TICK, ch, tv);
        end else if (pick < 76) begin
            if ($urandom_range(0, 6) != 0) begin
                tv = sb.axis_pos[ch] + 32'(int'($urandom_range(0, 40)) - 20);
            end
            send_word(MODE_SET, ch, tv);
        end else if (pick < 92) begin
            send_word(MODE_HOME, ch, tv);
        end else begin
            send_word(MODE_NONE, ch, tv);
        end
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            // occasional full pause until the pipe is empty
            if ($urandom_range(0, 49) == 0) drain();
            random_word();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int small_vals [NUM_REGS];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset backoffs, no idling
        send_word(MODE_TICK, 2'($urandom), $urandom);     // nothing moves, busy low
        send_word(MODE_NONE, 2'd3, 32'hFFFF_FFFF);         // unused mode
        send_word(MODE_SET, 2'd0, 32'h7FFF_FFFF);          // largest target
        send_word(MODE_SET, 2'd1, 32'h8000_0000);          // smallest target
        send_word(MODE_SET, 2'd2, 32'd3);
        send_word(MODE_SET, 2'd3, 32'hFFFF_FFFE);
        repeat (4) send_word(MODE_TICK, 2'($urandom), $urandom);
        send_word(MODE_NONE, 2'($urandom), $urandom);      // reports current busy
        send_word(MODE_HOME, 2'd2, 32'd0);                 // negative backoff
        send_word(MODE_SET, 2'd2, 32'd4);                  // shorten the homing move
        send_word(MODE_TICK, 2'd0, 32'd0);                 // motor 2 finishes homing
        send_word(MODE_HOME, 2'd3, 32'd0);                 // positive backoff
        send_word(MODE_SET, 2'd3, 32'hFFFF_FFFD);
        send_word(MODE_TICK, 2'd1, 32'd0);                 // motor 3 parks at -5
        send_word(MODE_SET, 2'd0, 32'd0);
        send_word(MODE_SET, 2'd1, 32'hFFFF_FFFF);
        repeat (3) send_word(MODE_TICK, 2'($urandom), $urandom);
        drain();

        // phase 1: small backoffs, zero on motor 0
        load_backoffs('{0, 5, -6, 1});
        send_word(MODE_HOME, 2'd0, 32'd0);                 // zero backoff homing
        send_word(MODE_TICK, 2'd0, 32'd0);                 // ends at once, parks at +5
        gaps_on     = 1'b1;
        ready_style = READY_RANDOM;
        run_random(180);
        drain();

        // phase 2: backoff extremes
        load_backoffs('{-1048576, 1048575, 0, -1});
        ready_style = READY_PERIODIC;
        run_random(120);
        drain();

        // phase 3: random small backoffs, first half free running
        for (int r = 0; r < NUM_REGS; r++) begin
            small_vals[r] = int'($urandom_range(0, 24)) - 12;
        end
        load_backoffs(small_vals);
        gaps_on     = 1'b0;
        ready_style = READY_ALWAYS;
        run_random(120);
        drain();
        gaps_on     = 1'b1;
        ready_style = READY_RANDOM;
        run_random(130);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
